// File: rtl/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, character codes and precedence lookup for the infix to
// postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

   localparam int DEFAULT_STACK_DEPTH = 32;

   localparam logic [7:0] CH_POW   = 8'h5E;
   localparam logic [7:0] CH_MUL   = 8'h2A;
   localparam logic [7:0] CH_DIV   = 8'h2F;
   localparam logic [7:0] CH_MOD   = 8'h25;
   localparam logic [7:0] CH_ADD   = 8'h2B;
   localparam logic [7:0] CH_SUB   = 8'h2D;
   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;

   localparam logic [2:0] PREC_NONE   = 3'd0;
   localparam logic [2:0] PREC_ADDSUB = 3'd1;
   localparam logic [2:0] PREC_MOD    = 3'd2;
   localparam logic [2:0] PREC_MULDIV = 3'd3;
   localparam logic [2:0] PREC_POW    = 3'd4;

   typedef enum logic [1:0] {
      ERR_NONE,
      ERR_OVERFLOW,
      ERR_UNMATCHED_CLOSE,
      ERR_UNMATCHED_OPEN
   } err_type;

   typedef enum logic [1:0] {
      KIND_OPERAND,
      KIND_OPERATOR,
      KIND_OPEN,
      KIND_CLOSE
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FLUSH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [7:0] symbol;
      kind_type   kind;
      logic [2:0] prec;
      logic       eoe;
   } token_type;

   typedef struct packed {
      logic [7:0] postfix_char;
      logic       has_char;
      logic       last;
      err_type    error_code;
   } rsp_type;

   function automatic logic [2:0] prec_of(input logic [7:0] c);
      logic [2:0] p;
      case (c)
         CH_POW:                   p = PREC_POW;
         CH_MUL, CH_DIV:           p = PREC_MULDIV;
         CH_MOD:                   p = PREC_MOD;
         CH_ADD, CH_SUB:           p = PREC_ADDSUB;
         default:                  p = PREC_NONE;
      endcase
      return p;
   endfunction

endpackage

// File: rtl/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard conversion of a single-character token stream to postfix.
//
//   channel  | handshake          | fields
//   ---------+--------------------+-------------------------------------------
//   token    | push / full        | req_symbol, req_end_of_expression
//   result   | empty / pop        | rsp_postfix_char, rsp_has_char,
//            |                    | rsp_last_of_expression, rsp_error_code
//
// An operand is taken from the input queue and then echoed. An operator or ')'
// is taken and then pops and emits stacked operators in turn; an end mark then
// flushes each remaining entry and closes the expression. The operator stack
// memory has a single read port.
// Reset is synchronous and clears the stack, both queues and the engine; no
// clearing pass. Either side may stall freely: two-entry queues decouple them.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter
   import itp_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
)(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_symbol,
   input  logic       req_end_of_expression,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_postfix_char,
   output logic       rsp_has_char,
   output logic       rsp_last_of_expression,
   output logic [1:0] rsp_error_code
);

   logic      tok_valid, tok_take;
   token_type tok;
   logic      rsp_push, rsp_full;
   rsp_type   rsp_wr, rsp_rd;

   itp_front u_front (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .symbol            (req_symbol),
      .end_of_expression (req_end_of_expression),
      .tok_valid         (tok_valid),
      .tok               (tok),
      .tok_take          (tok_take)
   );

   itp_exec #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_exec (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (tok_valid),
      .tok       (tok),
      .tok_take  (tok_take),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_wr),
      .rsp_full  (rsp_full)
   );

   itp_rsp_fifo u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_push),
      .wr_data (rsp_wr),
      .full    (rsp_full),
      .empty   (empty),
      .pop     (pop),
      .rd_data (rsp_rd)
   );

   assign rsp_postfix_char       = rsp_rd.postfix_char;
   assign rsp_has_char           = rsp_rd.has_char;
   assign rsp_last_of_expression = rsp_rd.last;
   assign rsp_error_code         = rsp_rd.error_code;

endmodule

// File: rtl/itp_front.sv
// ----------------------------------------------------------------------------
// itp_front
// Accepts tokens, classifies them and holds them in a two-entry queue
// for the execution unit.
// ----------------------------------------------------------------------------
module itp_front
   import itp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] symbol,
   input  logic       end_of_expression,
   output logic       tok_valid,
   output token_type  tok,
   input  logic       tok_take
);

   token_type  q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   token_type  tok_in;
   logic       accept, take;

   always_comb begin
      tok_in.symbol = symbol;
      tok_in.eoe    = end_of_expression;
      tok_in.prec   = prec_of(symbol);
      if (tok_in.prec != PREC_NONE) begin
         tok_in.kind = KIND_OPERATOR;
      end else if (symbol == CH_OPEN) begin
         tok_in.kind = KIND_OPEN;
      end else if (symbol == CH_CLOSE) begin
         tok_in.kind = KIND_CLOSE;
      end else begin
         tok_in.kind = KIND_OPERAND;
      end
   end

   assign full      = (count_ff == 2'd2);
   assign tok_valid = (count_ff != 2'd0);
   assign tok       = q_ff[rd_ptr_ff];
   assign accept    = push && !full;
   assign take      = tok_take && tok_valid;

   always_comb begin
      wr_ptr_in = accept ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, accept} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= tok_in;
      end
   end

endmodule

// File: rtl/itp_exec.sv
// ----------------------------------------------------------------------------
// itp_exec
// Operator stack engine: pops, pushes and flushes; it takes a new token only once the current one is finished.
// The final result of an end-marked expression is held back one place so
// that it can be flagged.
// ----------------------------------------------------------------------------
module itp_exec
   import itp_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
)(
   input  logic      clock,
   input  logic      reset,
   input  logic      tok_valid,
   input  token_type tok,
   output logic      tok_take,
   output logic      rsp_push,
   output rsp_type   rsp_data,
   input  logic      rsp_full
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   state_type        state_ff, state_in;
   token_type        cur_ff, cur_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             open_ff, open_in;
   logic             pend_valid_ff, pend_valid_in;
   rsp_type          pend_ff, pend_in;
   logic [7:0]       mem [STACK_DEPTH];
   logic [7:0]       rd_data_ff;
   logic [7:0]       fwd_data_ff;
   logic             fwd_sel_ff;
   logic [AW-1:0]    rd_addr;
   logic [7:0]       top;
   logic [2:0]       top_prec;
   logic             top_open;
   logic             stack_empty, stack_full;
   logic             emit, emit_ok, done_push;
   logic             push_en, pop_en;
   rsp_type          emit_data;
   state_type        next_after;

   assign top         = fwd_sel_ff ? fwd_data_ff : rd_data_ff;
   assign top_prec    = prec_of(top);
   assign top_open    = (top == CH_OPEN);
   assign stack_empty = (count_ff == '0);
   assign stack_full  = (count_ff == CW'(STACK_DEPTH));
   assign emit_ok     = cur_ff.eoe ? (!pend_valid_ff || !rsp_full) : !rsp_full;
   assign next_after  = cur_ff.eoe ? ST_FLUSH : ST_IDLE;

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      open_in   = open_ff;
      tok_take  = 1'b0;
      emit      = 1'b0;
      done_push = 1'b0;
      push_en   = 1'b0;
      pop_en    = 1'b0;
      emit_data = '0;
      emit_data.error_code = ERR_NONE;

      case (state_ff)
         ST_IDLE: begin
            if (tok_valid) begin
               tok_take = 1'b1;
               cur_in   = tok;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (cur_ff.kind)
               KIND_OPERAND: begin
                  emit                   = 1'b1;
                  emit_data.postfix_char = cur_ff.symbol;
                  emit_data.has_char     = 1'b1;
                  if (emit_ok) state_in = next_after;
               end
               KIND_OPERATOR, KIND_OPEN: begin
                  if (cur_ff.kind == KIND_OPERATOR && !stack_empty &&
                      top_prec >= cur_ff.prec) begin
                     emit                   = 1'b1;
                     emit_data.postfix_char = top;
                     emit_data.has_char     = 1'b1;
                     pop_en                 = emit_ok;
                  end else if (!stack_full) begin
                     push_en  = 1'b1;
                     state_in = next_after;
                  end else begin
                     emit                 = 1'b1;
                     emit_data.error_code = ERR_OVERFLOW;
                     if (emit_ok) state_in = next_after;
                  end
               end
               KIND_CLOSE: begin
                  if (stack_empty) begin
                     emit                 = 1'b1;
                     emit_data.error_code = ERR_UNMATCHED_CLOSE;
                     if (emit_ok) state_in = next_after;
                  end else if (top_open) begin
                     pop_en   = 1'b1;
                     state_in = next_after;
                  end else begin
                     emit                   = 1'b1;
                     emit_data.postfix_char = top;
                     emit_data.has_char     = 1'b1;
                     pop_en                 = emit_ok;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_FLUSH: begin
            if (!stack_empty) begin
               if (top_open) begin
                  pop_en  = 1'b1;
                  open_in = 1'b1;
               end else begin
                  emit                   = 1'b1;
                  emit_data.postfix_char = top;
                  emit_data.has_char     = 1'b1;
                  pop_en                 = emit_ok;
               end
            end else if (open_ff) begin
               emit                 = 1'b1;
               emit_data.error_code = ERR_UNMATCHED_OPEN;
               if (emit_ok) begin
                  open_in  = 1'b0;
                  state_in = ST_DONE;
               end
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            done_push = 1'b1;
            if (!rsp_full) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result path: direct for ordinary tokens, through the hold slot on end
   always_comb begin
      rsp_push      = 1'b0;
      rsp_data      = pend_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      if (done_push) begin
         rsp_push = !rsp_full;
         if (!pend_valid_ff) begin
            rsp_data            = '0;
            rsp_data.error_code = ERR_NONE;
         end
         rsp_data.last = 1'b1;
         if (!rsp_full) pend_valid_in = 1'b0;
      end else if (emit) begin
         if (!cur_ff.eoe) begin
            rsp_push = !rsp_full;
            rsp_data = emit_data;
         end else if (emit_ok) begin
            rsp_push      = pend_valid_ff;
            pend_in       = emit_data;
            pend_valid_in = 1'b1;
         end
      end
   end

   always_comb begin
      if (push_en) begin
         count_in = count_ff + CW'(1);
      end else if (pop_en) begin
         count_in = count_ff - CW'(1);
      end else begin
         count_in = count_ff;
      end
      rd_addr = (count_in == '0) ? '0 : AW'(count_in - CW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         open_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         fwd_sel_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         open_ff       <= open_in;
         pend_valid_ff <= pend_valid_in;
         fwd_sel_ff    <= push_en;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      pend_ff <= pend_in;
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         mem[count_ff[AW-1:0]] <= cur_ff.symbol;
      end
      rd_data_ff  <= mem[rd_addr];
      fwd_data_ff <= cur_ff.symbol;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result transfer into a full queue");

   a_error_has_no_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp_data.error_code != ERR_NONE) |-> !rsp_data.has_char)
      else $error("error result carries a character");

   a_last_only_at_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp_data.last) |-> (state_ff == ST_DONE))
      else $error("last flag outside end of expression");

   a_done_clears_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !rsp_full) |=> (!pend_valid_ff && state_ff == ST_IDLE))
      else $error("hold slot not released at end of expression");

endmodule

// File: rtl/itp_rsp_fifo.sv
// ----------------------------------------------------------------------------
// itp_rsp_fifo
// Two-entry result queue between the stack engine and the result port.
// ----------------------------------------------------------------------------
module itp_rsp_fifo
   import itp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  rsp_type wr_data,
   output logic    full,
   output logic    empty,
   input  logic    pop,
   output rsp_type rd_data
);

   rsp_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_wr, do_rd;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign rd_data = q_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !full;
   assign do_rd   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_wr ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         q_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
